/* hw/rtl/rbis_pkg.sv */
// Shared types, constants and the arithmetic sequence of the rigid body integration step.
`timescale 1ns / 1ps
package rbis_pkg;

	localparam int unsigned ACC_W       = 52;
	localparam int unsigned CNT_W       = 6;
	localparam int unsigned UOP_COUNT   = 62;
	localparam int unsigned UOP_BUILD_R = 20;
	localparam int unsigned SQRT_STEPS  = 32;
	localparam int unsigned DIV_STEPS   = 31;

	localparam logic signed [31:0] ONE_Q30       = 32'sh4000_0000;
	localparam logic signed [32:0] GRAVITY_FIXED = 33'sd642908;

	localparam logic [16:0]        RST_TIME_STEP    = 17'd1092;
	localparam logic [30:0]        RST_INVERSE_MASS = 31'd65536;
	localparam logic signed [31:0] RST_INV_DIAG     = 32'sd65536;

	typedef enum logic [2:0] {
		CFG_TIME_STEP    = 3'd0,
		CFG_INVERSE_MASS = 3'd1,
		CFG_INV_XX       = 3'd2,
		CFG_INV_YY       = 3'd3,
		CFG_INV_ZZ       = 3'd4,
		CFG_INV_XY       = 3'd5,
		CFG_INV_XZ       = 3'd6,
		CFG_INV_YZ       = 3'd7
	} cfg_idx_t;

	// operand sources of the shared multiplier
	typedef enum logic [3:0] {
		GRP_F, GRP_T, GRP_DT, GRP_DT2, GRP_IM, GRP_AV, GRP_Q, GRP_R,
		GRP_II, GRP_BV, GRP_CV, GRP_HV, GRP_MOM, GRP_GRAV
	} grp_t;

	typedef enum logic [1:0] {SH_16, SH_17, SH_30} shift_t;

	typedef enum logic [2:0] {BS_ZERO, BS_ACC, BS_PV, BS_MOM, BS_Q} base_t;

	typedef enum logic [3:0] {
		D_NONE, D_DT2, D_AV, D_POS, D_MOM, D_TMP, D_BV, D_CV, D_HV, D_NQ
	} dst_t;

	typedef struct packed {
		grp_t       a_grp;
		logic [3:0] a_idx;
		grp_t       b_grp;
		logic [3:0] b_idx;
		shift_t     sh;
		base_t      base;
		logic       neg;
		dst_t       dst;
		logic [3:0] dst_idx;
	} uop_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_PLACE, OP_MUL, OP_ACC, OP_BUILD_R, OP_NORM_LOAD,
		OP_SHR, OP_SHL, OP_SQ_MUL, OP_SQ_ACC, OP_SQRT_INIT, OP_SQRT_STEP,
		OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE, OP_IDENT, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		uop_t       uop;
		logic [1:0] part;
	} cmd_t;

	typedef struct packed {
		logic nq_zero;
		logic need_shr;
		logic need_shl;
	} status_t;

	// quaternion index pairs of the rotation temporaries xx yy zz xy xz yz wx wy wz
	localparam logic [1:0] TMP_A [9] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
	localparam logic [1:0] TMP_B [9] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};
	// row-major inverse inertia to register slot xx yy zz xy xz yz
	localparam logic [2:0] II_MAP [9] = '{3'd0, 3'd3, 3'd4, 3'd3, 3'd1, 3'd5, 3'd4, 3'd5, 3'd2};
	// Hamilton product terms q*h, three per output part
	localparam logic [1:0] NQ_A [12] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
	localparam logic [1:0] NQ_B [12] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1,
		2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
	localparam logic NQ_NEG [12] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > ACC_W'(64'sd2147483647))
			r = 32'sh7FFF_FFFF;
		else if (v < ACC_W'(-64'sd2147483648))
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic uop_t mk(input grp_t ag, input logic [3:0] ai, input grp_t bg,
		input logic [3:0] bi, input shift_t sh, input base_t bs, input logic ng,
		input dst_t d, input logic [3:0] di);
		uop_t u;
		u.a_grp = ag; u.a_idx = ai; u.b_grp = bg; u.b_idx = bi;
		u.sh = sh; u.base = bs; u.neg = ng; u.dst = d; u.dst_idx = di;
		return u;
	endfunction

	function automatic logic [1:0] third(input logic [3:0] k);
		logic [1:0] i;
		if (k >= 4'd9)
			i = 2'd3;
		else if (k >= 4'd6)
			i = 2'd2;
		else if (k >= 4'd3)
			i = 2'd1;
		else
			i = 2'd0;
		return i;
	endfunction

	// one multiply-accumulate of the step sequence
	function automatic uop_t uop_at(input logic [CNT_W-1:0] step);
		uop_t u;
		logic [3:0] k;
		logic [1:0] i;
		logic [1:0] j;
		logic [3:0] rij;
		logic [3:0] rji;
		u = mk(GRP_DT, 4'd0, GRP_DT, 4'd0, SH_16, BS_ZERO, 1'b0, D_NONE, 4'd0);
		k = 4'd0;
		i = 2'd0;
		j = 2'd0;
		if (step == 6'd0) begin
			u = mk(GRP_DT, 4'd0, GRP_DT, 4'd0, SH_16, BS_ZERO, 1'b0, D_DT2, 4'd0);
		end else if (step <= 6'd7) begin
			case (step)
				6'd1: u = mk(GRP_F, 4'd0, GRP_IM, 4'd0, SH_16, BS_ZERO, 1'b0, D_AV, 4'd0);
				6'd2: u = mk(GRP_AV, 4'd0, GRP_DT2, 4'd0, SH_16, BS_PV, 1'b0, D_POS, 4'd0);
				6'd3: u = mk(GRP_F, 4'd1, GRP_IM, 4'd0, SH_16, BS_ZERO, 1'b0, D_AV, 4'd0);
				6'd4: u = mk(GRP_AV, 4'd0, GRP_DT2, 4'd0, SH_16, BS_PV, 1'b0, D_NONE, 4'd1);
				6'd5: u = mk(GRP_GRAV, 4'd0, GRP_DT2, 4'd0, SH_16, BS_ACC, 1'b1, D_POS, 4'd1);
				6'd6: u = mk(GRP_F, 4'd2, GRP_IM, 4'd0, SH_16, BS_ZERO, 1'b0, D_AV, 4'd0);
				6'd7: u = mk(GRP_AV, 4'd0, GRP_DT2, 4'd0, SH_16, BS_PV, 1'b0, D_POS, 4'd2);
				default: u = mk(GRP_DT, 4'd0, GRP_DT, 4'd0, SH_16, BS_ZERO, 1'b0, D_NONE, 4'd0);
			endcase
		end else if (step <= 6'd10) begin
			k = 4'(step - 6'd8);
			u = mk(GRP_T, k, GRP_DT, 4'd0, SH_16, BS_MOM, 1'b0, D_MOM, k);
		end else if (step <= 6'd19) begin
			k = 4'(step - 6'd11);
			u = mk(GRP_Q, {2'b0, TMP_A[k]}, GRP_Q, {2'b0, TMP_B[k]}, SH_30, BS_ZERO, 1'b0,
				D_TMP, k);
		end else if (step <= 6'd46) begin
			if (step <= 6'd28)
				k = 4'(step - 6'd20);
			else if (step <= 6'd37)
				k = 4'(step - 6'd29);
			else
				k = 4'(step - 6'd38);
			i = third(k);
			j = 2'(k - {1'b0, i, 1'b0} - {2'b0, i});
			rij = 4'({i, 1'b0} + {2'b0, i} + {2'b0, j});
			rji = 4'({j, 1'b0} + {2'b0, j} + {2'b0, i});
			if (step <= 6'd28)
				u = mk(GRP_R, rji, GRP_MOM, {2'b0, j}, SH_30,
					(j == 2'd0) ? BS_ZERO : BS_ACC, 1'b0,
					(j == 2'd2) ? D_BV : D_NONE, {2'b0, i});
			else if (step <= 6'd37)
				u = mk(GRP_II, {1'b0, II_MAP[rij]}, GRP_BV, {2'b0, j}, SH_16,
					(j == 2'd0) ? BS_ZERO : BS_ACC, 1'b0,
					(j == 2'd2) ? D_CV : D_NONE, {2'b0, i});
			else
				u = mk(GRP_R, rij, GRP_CV, {2'b0, j}, SH_30,
					(j == 2'd0) ? BS_ZERO : BS_ACC, 1'b0,
					(j == 2'd2) ? D_HV : D_NONE, {2'b0, i});
		end else if (step <= 6'd49) begin
			k = 4'(step - 6'd47);
			u = mk(GRP_HV, k, GRP_DT, 4'd0, SH_17, BS_ZERO, 1'b0, D_HV, k);
		end else if (step <= 6'd61) begin
			k = 4'(step - 6'd50);
			i = third(k);
			u = mk(GRP_Q, {2'b0, NQ_A[k]}, GRP_HV, {2'b0, NQ_B[k]}, SH_16,
				(k == 4'({i, 1'b0} + {2'b0, i})) ? BS_Q : BS_ACC, NQ_NEG[k],
				D_NQ, {2'b0, i});
		end
		return u;
	endfunction

endpackage

/* hw/rtl/rbis_ctrl.sv */
// Sequencer of the integration step: issues datapath commands and owns both handshakes.
`timescale 1ns / 1ps
module rbis_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_place,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rbis_pkg::status_t status,
	output rbis_pkg::cmd_t   cmd
);
	import rbis_pkg::*;

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_PLACE  = 15'b000000000000010,
		ST_MUL    = 15'b000000000000100,
		ST_ACC    = 15'b000000000001000,
		ST_BUILD  = 15'b000000000010000,
		ST_NLOAD  = 15'b000000000100000,
		ST_NSHIFT = 15'b000000001000000,
		ST_SQMUL  = 15'b000000010000000,
		ST_SQACC  = 15'b000000100000000,
		ST_SQINIT = 15'b000001000000000,
		ST_SQSTEP = 15'b000010000000000,
		ST_DINIT  = 15'b000100000000000,
		ST_DSTEP  = 15'b001000000000000,
		ST_DDONE  = 15'b010000000000000,
		ST_FINISH = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0] part_q, part_d;
	logic out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		part_d   = part_q;
		cmd.op   = OP_NONE;
		cmd.uop  = uop_at(cnt_q);
		cmd.part = part_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					cnt_d   = '0;
					state_d = in_place ? ST_PLACE : ST_MUL;
				end
			end
			ST_PLACE: begin
				cmd.op  = OP_PLACE;
				state_d = ST_FINISH;
			end
			ST_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op = OP_ACC;
				if (cnt_q == CNT_W'(UOP_COUNT - 1)) begin
					state_d = ST_NLOAD;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = (cnt_q == CNT_W'(UOP_BUILD_R - 1)) ? ST_BUILD : ST_MUL;
				end
			end
			ST_BUILD: begin
				cmd.op  = OP_BUILD_R;
				state_d = ST_MUL;
			end
			ST_NLOAD: begin
				cmd.op  = OP_NORM_LOAD;
				state_d = ST_NSHIFT;
			end
			ST_NSHIFT: begin
				if (status.nq_zero) begin
					cmd.op  = OP_IDENT;
					state_d = ST_FINISH;
				end else if (status.need_shr) begin
					cmd.op = OP_SHR;
				end else if (status.need_shl) begin
					cmd.op = OP_SHL;
				end else begin
					part_d  = 2'd0;
					state_d = ST_SQMUL;
				end
			end
			ST_SQMUL: begin
				cmd.op  = OP_SQ_MUL;
				state_d = ST_SQACC;
			end
			ST_SQACC: begin
				cmd.op = OP_SQ_ACC;
				part_d = part_q + 1'b1;
				state_d = (part_q == 2'd3) ? ST_SQINIT : ST_SQMUL;
			end
			ST_SQINIT: begin
				cmd.op  = OP_SQRT_INIT;
				cnt_d   = '0;
				state_d = ST_SQSTEP;
			end
			ST_SQSTEP: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					part_d  = 2'd0;
					state_d = ST_DINIT;
				end
			end
			ST_DINIT: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = ST_DDONE;
			end
			ST_DDONE: begin
				cmd.op  = OP_DIV_DONE;
				part_d  = part_q + 1'b1;
				state_d = (part_q == 2'd3) ? ST_FINISH : ST_DINIT;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			part_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			part_q  <= part_d;
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/rbis_datapath.sv */
// Body state, configuration, shared multiplier, normaliser, square root and divider.
`timescale 1ns / 1ps
module rbis_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  rbis_pkg::cmd_t   cmd,
	output rbis_pkg::status_t status,
	input  logic [191:0]     in_data,
	output logic [319:0]     out_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import rbis_pkg::*;

	logic [16:0] dt_q;
	logic [30:0] im_q;
	logic signed [31:0] ii_q [6];

	logic signed [31:0] pos_q [3];
	logic signed [31:0] prev_q [3];
	logic signed [31:0] mom_q [3];
	logic signed [31:0] quat_q [4];

	logic signed [31:0] f_q [3];
	logic signed [31:0] t_q [3];
	logic [16:0] dt2_q;
	logic signed [31:0] av_q;
	logic signed [31:0] tmp_q [9];
	logic signed [31:0] rot_q [9];
	logic signed [31:0] bv_q [3];
	logic signed [31:0] cv_q [3];
	logic signed [31:0] hv_q [3];
	logic signed [ACC_W-1:0] nq_q [4];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [65:0] prod_s1;

	logic [ACC_W-1:0] mag_q [4];
	logic [3:0] sgn_q;
	logic [61:0] sq_q;
	logic [62:0] rad_q;
	logic [62:0] root_q;
	logic [62:0] bit_q;
	logic [32:0] rem_q;
	logic [30:0] dsh_q;
	logic [30:0] quo_q;
	logic [319:0] out_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] shifted;
	logic signed [ACC_W-1:0] term, base, acc_next;
	logic signed [31:0] sat_val;
	logic [1:0] di;
	logic [63:0] sq_trial;
	logic [32:0] div_trial;
	logic [30:0] quo_clamped;
	logic signed [31:0] rot_new [9];

	function automatic logic signed [32:0] opnd(input grp_t g, input logic [3:0] idx);
		logic signed [32:0] v;
		case (g)
			GRP_F:    v = 33'(f_q[idx[1:0]]);
			GRP_T:    v = 33'(t_q[idx[1:0]]);
			GRP_DT:   v = {16'b0, dt_q};
			GRP_DT2:  v = {16'b0, dt2_q};
			GRP_IM:   v = {2'b0, im_q};
			GRP_AV:   v = 33'(av_q);
			GRP_Q:    v = 33'(quat_q[idx[1:0]]);
			GRP_R:    v = 33'(rot_q[idx]);
			GRP_II:   v = 33'(ii_q[idx[2:0]]);
			GRP_BV:   v = 33'(bv_q[idx[1:0]]);
			GRP_CV:   v = 33'(cv_q[idx[1:0]]);
			GRP_HV:   v = 33'(hv_q[idx[1:0]]);
			GRP_MOM:  v = 33'(mom_q[idx[1:0]]);
			GRP_GRAV: v = GRAVITY_FIXED;
			default:  v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] clampq(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'(ONE_Q30))
			r = ONE_Q30;
		else if (v < -35'(ONE_Q30))
			r = -ONE_Q30;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [34:0] x35(input logic signed [31:0] v);
		return 35'(v);
	endfunction

	assign di = cmd.uop.dst_idx[1:0];

	always_comb begin
		if (cmd.op == OP_SQ_MUL) begin
			mul_a = {3'b0, mag_q[cmd.part][29:0]};
			mul_b = {3'b0, mag_q[cmd.part][29:0]};
		end else begin
			mul_a = opnd(cmd.uop.a_grp, cmd.uop.a_idx);
			mul_b = opnd(cmd.uop.b_grp, cmd.uop.b_idx);
		end
	end

	always_comb begin
		case (cmd.uop.sh)
			SH_16:   shifted = prod_s1 >>> 16;
			SH_17:   shifted = prod_s1 >>> 17;
			SH_30:   shifted = prod_s1 >>> 30;
			default: shifted = prod_s1;
		endcase
		term = shifted[ACC_W-1:0];
		case (cmd.uop.base)
			BS_ACC:  base = acc_q;
			BS_PV:   base = (ACC_W'(pos_q[di]) <<< 1) - ACC_W'(prev_q[di]);
			BS_MOM:  base = ACC_W'(mom_q[di]);
			BS_Q:    base = ACC_W'(quat_q[di]);
			default: base = '0;
		endcase
		acc_next = cmd.uop.neg ? (base - term) : (base + term);
		sat_val  = sat32(acc_next);
	end

	// rotation matrix of the current orientation, rows first
	always_comb begin
		rot_new[0] = clampq(x35(ONE_Q30) - ((x35(tmp_q[1]) + x35(tmp_q[2])) <<< 1));
		rot_new[1] = clampq((x35(tmp_q[3]) - x35(tmp_q[8])) <<< 1);
		rot_new[2] = clampq((x35(tmp_q[4]) + x35(tmp_q[7])) <<< 1);
		rot_new[3] = clampq((x35(tmp_q[3]) + x35(tmp_q[8])) <<< 1);
		rot_new[4] = clampq(x35(ONE_Q30) - ((x35(tmp_q[0]) + x35(tmp_q[2])) <<< 1));
		rot_new[5] = clampq((x35(tmp_q[5]) - x35(tmp_q[6])) <<< 1);
		rot_new[6] = clampq((x35(tmp_q[4]) - x35(tmp_q[7])) <<< 1);
		rot_new[7] = clampq((x35(tmp_q[5]) + x35(tmp_q[6])) <<< 1);
		rot_new[8] = clampq(x35(ONE_Q30) - ((x35(tmp_q[0]) + x35(tmp_q[1])) <<< 1));
	end

	assign sq_trial    = {1'b0, root_q} + {1'b0, bit_q};
	assign div_trial   = {rem_q[31:0], dsh_q[30]};
	assign quo_clamped = (quo_q > 31'(ONE_Q30)) ? 31'(ONE_Q30) : quo_q;

	always_comb begin
		status.nq_zero  = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0)
			&& (mag_q[3] == '0);
		status.need_shr = (|mag_q[0][ACC_W-1:30]) || (|mag_q[1][ACC_W-1:30])
			|| (|mag_q[2][ACC_W-1:30]) || (|mag_q[3][ACC_W-1:30]);
		status.need_shl = !(mag_q[0][29] || mag_q[1][29] || mag_q[2][29] || mag_q[3][29]);
	end

	assign out_data = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q     <= RST_TIME_STEP;
			im_q     <= RST_INVERSE_MASS;
			ii_q[0]  <= RST_INV_DIAG;
			ii_q[1]  <= RST_INV_DIAG;
			ii_q[2]  <= RST_INV_DIAG;
			ii_q[3]  <= '0;
			ii_q[4]  <= '0;
			ii_q[5]  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TIME_STEP:    dt_q    <= cfg_data[16:0];
				CFG_INVERSE_MASS: im_q    <= cfg_data[30:0];
				CFG_INV_XX:       ii_q[0] <= cfg_data;
				CFG_INV_YY:       ii_q[1] <= cfg_data;
				CFG_INV_ZZ:       ii_q[2] <= cfg_data;
				CFG_INV_XY:       ii_q[3] <= cfg_data;
				CFG_INV_XZ:       ii_q[4] <= cfg_data;
				CFG_INV_YZ:       ii_q[5] <= cfg_data;
				default:          dt_q    <= dt_q;
			endcase
		end
	end

	// body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				pos_q[n]  <= '0;
				prev_q[n] <= '0;
				mom_q[n]  <= '0;
			end
			quat_q[0] <= ONE_Q30;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
		end else begin
			case (cmd.op)
				OP_PLACE: begin
					for (int n = 0; n < 3; n++) begin
						pos_q[n]  <= f_q[n];
						prev_q[n] <= f_q[n];
						mom_q[n]  <= t_q[n];
					end
					quat_q[0] <= ONE_Q30;
					quat_q[1] <= '0;
					quat_q[2] <= '0;
					quat_q[3] <= '0;
				end
				OP_ACC: begin
					if (cmd.uop.dst == D_POS) begin
						prev_q[di] <= pos_q[di];
						pos_q[di]  <= sat_val;
					end else if (cmd.uop.dst == D_MOM) begin
						mom_q[di] <= sat_val;
					end
				end
				OP_IDENT: begin
					quat_q[0] <= ONE_Q30;
					quat_q[1] <= '0;
					quat_q[2] <= '0;
					quat_q[3] <= '0;
				end
				OP_DIV_DONE: begin
					quat_q[cmd.part] <= sgn_q[cmd.part] ? -32'(quo_clamped)
						: 32'(quo_clamped);
				end
				default: begin
					quat_q[0] <= quat_q[0];
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				for (int n = 0; n < 3; n++) begin
					f_q[n] <= in_data[32*n +: 32];
					t_q[n] <= in_data[96 + 32*n +: 32];
				end
			end
			OP_MUL, OP_SQ_MUL: begin
				prod_s1 <= mul_a * mul_b;
			end
			OP_ACC: begin
				acc_q <= acc_next;
				case (cmd.uop.dst)
					D_DT2:   dt2_q <= sat_val[16:0];
					D_AV:    av_q <= sat_val;
					D_TMP:   tmp_q[cmd.uop.dst_idx] <= sat_val;
					D_BV:    bv_q[di] <= sat_val;
					D_CV:    cv_q[di] <= sat_val;
					D_HV:    hv_q[di] <= sat_val;
					D_NQ:    nq_q[di] <= acc_next;
					default: ;
				endcase
			end
			OP_BUILD_R: begin
				for (int n = 0; n < 9; n++)
					rot_q[n] <= rot_new[n];
			end
			OP_NORM_LOAD: begin
				for (int n = 0; n < 4; n++) begin
					mag_q[n] <= nq_q[n][ACC_W-1] ? ACC_W'(-nq_q[n]) : ACC_W'(nq_q[n]);
					sgn_q[n] <= nq_q[n][ACC_W-1];
				end
				sq_q <= '0;
			end
			OP_SHR: begin
				for (int n = 0; n < 4; n++)
					mag_q[n] <= mag_q[n] >> 1;
			end
			OP_SHL: begin
				for (int n = 0; n < 4; n++)
					mag_q[n] <= mag_q[n] << 1;
			end
			OP_SQ_ACC: begin
				sq_q <= sq_q + prod_s1[61:0];
			end
			OP_SQRT_INIT: begin
				rad_q  <= {1'b0, sq_q};
				root_q <= '0;
				bit_q  <= {1'b1, 62'b0};
			end
			OP_SQRT_STEP: begin
				if ({1'b0, rad_q} >= sq_trial) begin
					rad_q  <= rad_q - sq_trial[62:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT: begin
				rem_q <= {4'b0, mag_q[cmd.part][29:1]};
				dsh_q <= {mag_q[cmd.part][0], 30'b0};
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				// restoring division, one quotient bit a cycle
				if (div_trial >= {1'b0, root_q[31:0]}) begin
					rem_q <= div_trial - {1'b0, root_q[31:0]};
					quo_q <= {quo_q[29:0], 1'b1};
				end else begin
					rem_q <= div_trial;
					quo_q <= {quo_q[29:0], 1'b0};
				end
				dsh_q <= dsh_q << 1;
			end
			OP_OUT: begin
				out_q <= {mom_q[2], mom_q[1], mom_q[0], quat_q[3], quat_q[2], quat_q[1],
					quat_q[0], pos_q[2], pos_q[1], pos_q[0]};
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

endmodule

/* hw/rtl/rigid_body_integration_step_unit.sv */
// Top level of the rigid body integration step unit.
`timescale 1ns / 1ps
// Advances one rigid body by one tick per step transaction (position Verlet with
// gravity in y, torque into angular momentum, world inverse inertia through the
// rotation of the current orientation, quaternion update and renormalisation), or
// places the body with zero velocity at the force fields as position, the torque
// fields as angular momentum and identity orientation when tuser is set. Every input
// transaction gives one output transaction with the new state. A step item runs 62
// multiply-accumulate operations on one shared 33x33 multiplier, a normalising
// shift of one bit per step, a bit-serial square root and four restoring divisions;
// a step whose updated quaternion is all zero falls back to identity orientation.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. Configuration writes are taken at any time but must
// only be issued while the unit is idle.
module rigid_body_integration_step_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// force_x, force_y, force_z, torque_x, torque_y, torque_z
	input  logic [191:0] s_axis_tdata,
	// command
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, momentum_x, momentum_y, momentum_z
	output logic [319:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import rbis_pkg::*;

	cmd_t    cmd;
	status_t status;

	rbis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_place  (s_axis_tuser[0]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	rbis_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

`ifndef ASSERT_OFF
	// one transaction in work at a time
	ap_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a transaction is in work");

	// the normaliser never delivers a quaternion part beyond one
	ap_quat_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[127:96]) <= ONE_Q30
		&& $signed(m_axis_tdata[127:96]) >= -ONE_Q30))
		else $error("quat_w out of range");

	ap_quat_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[159:128]) <= ONE_Q30
		&& $signed(m_axis_tdata[159:128]) >= -ONE_Q30))
		else $error("quat_x out of range");
`endif

endmodule
